// ===== src/pcs_pkg.sv =====
// Package with shared types, constants and codes of the PID step core.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int DataW    = 32;
  localparam int PerW     = 16;
  localparam int AddrW    = 5;
  localparam int QuoW     = DataW + 1;
  localparam int MulW     = DataW + 2;
  localparam int ProdW    = 2 * MulW;
  localparam int IntW     = 64;
  localparam int AccW     = 100;
  localparam int FracW    = 16;
  localparam int DivSteps = QuoW;
  localparam int CntW     = 6;

  localparam logic signed [DataW-1:0] KpRst      = 32'sd65536;
  localparam logic signed [DataW-1:0] KiRst      = '0;
  localparam logic signed [DataW-1:0] KdRst      = '0;
  localparam logic                    FixedRst   = 1'b1;
  localparam logic [PerW-1:0]         PeriodRst  = 16'd1;
  localparam logic                    LimEnRst   = 1'b0;
  localparam logic signed [DataW-1:0] OutLowRst  = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] OutHighRst = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ReqErrOnly = 2'd0,
    ReqRate    = 2'd1,
    ReqSum     = 2'd2,
    ReqAll     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    RegKp      = 3'd0,
    RegKi      = 3'd1,
    RegKd      = 3'd2,
    RegFixed   = 3'd3,
    RegPeriod  = 3'd4,
    RegLimEn   = 3'd5,
    RegOutLow  = 3'd6,
    RegOutHigh = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StStart, StDiv, StEdt, StInteg, StKp, StKd, StKiLo, StKiHi, StLast, StFinish
  } state_e;

  typedef enum logic [2:0] {
    MulNone, MulEdt, MulKp, MulKd, MulKiLo, MulKiHi
  } mul_sel_e;

  typedef enum logic [2:0] {
    AccNone, AccAdd, AccSub, AccAddHi, AccInteg
  } acc_sel_e;

  typedef struct packed {
    logic signed [DataW-1:0] kp;
    logic signed [DataW-1:0] ki;
    logic signed [DataW-1:0] kd;
    logic                    fixed_interval;
    logic [PerW-1:0]         period;
    logic                    limit_enable;
    logic signed [DataW-1:0] out_low;
    logic signed [DataW-1:0] out_high;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    mul_sel_e mul_sel;
    acc_sel_e acc_sel;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic      first;
    req_type_e req_type;
    logic      div_last;
    logic      out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/pcs_if.sv =====
// Handshake interfaces for the input and result channels of the PID step core.
`timescale 1ns / 1ps
`default_nettype none
interface pcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] error_in;
  logic signed [31:0] rate_in;
  logic signed [31:0] sum_in;
  logic [31:0]        time_ms;
  modport source (output valid, req_type, error_in, rate_in, sum_in, time_ms, input ready);
  modport sink (input valid, req_type, error_in, rate_in, sum_in, time_ms, output ready);
endinterface

interface pcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               limited;
  modport source (output valid, drive, limited, input ready);
  modport sink (input valid, drive, limited, output ready);
endinterface
`default_nettype wire

// ===== src/pid_controller_step_core.sv =====
// Top level of the PID step core: registers, sequencer and datapath.
// Usage:
// An item enters on in_i (valid/ready) and carries req_type, error_in, rate_in,
// sum_in and time_ms. Exactly one item leaves on out_o with drive and limited.
// Gains, interval mode and output bounds are written through the APB-style
// port; the user must do so only while the core is idle, as the block itself
// does not enforce it. pready is always high and reads return values.
// The core works on one item at a time. The all-measured form and the first
// sample go straight to the gain products, the measured-rate form adds its
// integral update, and forms that compute the rate internally also pass
// through the bit-serial divider. The next item can be accepted once the
// result is registered. The single shared 34 by 34 multiplier forms the gain
// products one per cycle. A new item is accepted whenever the sequencer is
// idle, even while the previous result waits in the output register. If the
// receiver stalls, the result is held and the next item waits at its final
// step until the output register frees. Reset restores the register defaults,
// clears the internal integral, previous error and previous timestamp, and
// marks the next sample as the first one.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_step_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pcs_in_if.sink                              in_i,
  pcs_out_if.source                           out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pcs_pkg::AddrW-1:0]      paddr,
  input  wire logic [pcs_pkg::DataW-1:0]      pwdata,
  output logic      [pcs_pkg::DataW-1:0]      prdata,
  output logic                                pready
);

  pcs_pkg::cfg_t cfg;
  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  pcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (in_i.req_type),
    .error_in_i  (in_i.error_in),
    .rate_in_i   (in_i.rate_in),
    .sum_in_i    (in_i.sum_in),
    .time_ms_i   (in_i.time_ms),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .drive_o     (out_o.drive),
    .limited_o   (out_o.limited)
  );

endmodule
`default_nettype wire

// ===== src/pcs_cfg.sv =====
// APB-style configuration register file of the PID step core.
`timescale 1ns / 1ps
`default_nettype none
module pcs_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcs_pkg::AddrW-1:0]   paddr,
  input  wire logic [pcs_pkg::DataW-1:0]   pwdata,
  output logic      [pcs_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output pcs_pkg::cfg_t                    cfg_o
);

  pcs_pkg::cfg_t    cfg_q;
  pcs_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = pcs_pkg::reg_idx_e'(paddr[pcs_pkg::AddrW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp             <= pcs_pkg::KpRst;
      cfg_q.ki             <= pcs_pkg::KiRst;
      cfg_q.kd             <= pcs_pkg::KdRst;
      cfg_q.fixed_interval <= pcs_pkg::FixedRst;
      cfg_q.period         <= pcs_pkg::PeriodRst;
      cfg_q.limit_enable   <= pcs_pkg::LimEnRst;
      cfg_q.out_low        <= pcs_pkg::OutLowRst;
      cfg_q.out_high       <= pcs_pkg::OutHighRst;
    end else if (wr) begin
      case (idx)
        pcs_pkg::RegKp:      cfg_q.kp             <= $signed(pwdata);
        pcs_pkg::RegKi:      cfg_q.ki             <= $signed(pwdata);
        pcs_pkg::RegKd:      cfg_q.kd             <= $signed(pwdata);
        pcs_pkg::RegFixed:   cfg_q.fixed_interval <= pwdata[0];
        pcs_pkg::RegPeriod:  cfg_q.period         <= pwdata[pcs_pkg::PerW-1:0];
        pcs_pkg::RegLimEn:   cfg_q.limit_enable   <= pwdata[0];
        pcs_pkg::RegOutLow:  cfg_q.out_low        <= $signed(pwdata);
        pcs_pkg::RegOutHigh: cfg_q.out_high       <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pcs_pkg::RegKp:      prdata = cfg_q.kp;
      pcs_pkg::RegKi:      prdata = cfg_q.ki;
      pcs_pkg::RegKd:      prdata = cfg_q.kd;
      pcs_pkg::RegFixed:   prdata = {{(pcs_pkg::DataW-1){1'b0}}, cfg_q.fixed_interval};
      pcs_pkg::RegPeriod:  prdata = {{(pcs_pkg::DataW-pcs_pkg::PerW){1'b0}}, cfg_q.period};
      pcs_pkg::RegLimEn:   prdata = {{(pcs_pkg::DataW-1){1'b0}}, cfg_q.limit_enable};
      pcs_pkg::RegOutLow:  prdata = cfg_q.out_low;
      pcs_pkg::RegOutHigh: prdata = cfg_q.out_high;
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/pcs_ctrl.sv =====
// Sequencing state machine of the PID step core.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t      cmd_o
);

  pcs_pkg::state_e state_q, state_d;
  logic            need_div, need_int;

  assign need_div = !sts_i.first &&
                    (sts_i.req_type == pcs_pkg::ReqErrOnly || sts_i.req_type == pcs_pkg::ReqSum);
  assign need_int = !sts_i.first &&
                    (sts_i.req_type == pcs_pkg::ReqErrOnly || sts_i.req_type == pcs_pkg::ReqRate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.mul_sel = pcs_pkg::MulNone;
    cmd_o.acc_sel = pcs_pkg::AccNone;
    cmd_o.finish  = 1'b0;
    case (state_q)
      pcs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pcs_pkg::StStart;
        end
      end
      pcs_pkg::StStart: begin
        if (need_div) begin
          state_d = pcs_pkg::StDiv;
        end else if (need_int) begin
          state_d = pcs_pkg::StEdt;
        end else begin
          state_d = pcs_pkg::StKp;
        end
      end
      pcs_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = need_int ? pcs_pkg::StEdt : pcs_pkg::StKp;
        end
      end
      pcs_pkg::StEdt: begin
        cmd_o.mul_sel = pcs_pkg::MulEdt;
        state_d       = pcs_pkg::StInteg;
      end
      pcs_pkg::StInteg: begin
        cmd_o.acc_sel = pcs_pkg::AccInteg;
        cmd_o.mul_sel = pcs_pkg::MulKp;
        state_d       = pcs_pkg::StKd;
      end
      pcs_pkg::StKp: begin
        cmd_o.mul_sel = pcs_pkg::MulKp;
        state_d       = pcs_pkg::StKd;
      end
      pcs_pkg::StKd: begin
        cmd_o.mul_sel = pcs_pkg::MulKd;
        cmd_o.acc_sel = pcs_pkg::AccAdd;
        state_d       = pcs_pkg::StKiLo;
      end
      pcs_pkg::StKiLo: begin
        cmd_o.mul_sel = pcs_pkg::MulKiLo;
        cmd_o.acc_sel = pcs_pkg::AccSub;
        state_d       = pcs_pkg::StKiHi;
      end
      pcs_pkg::StKiHi: begin
        cmd_o.mul_sel = pcs_pkg::MulKiHi;
        cmd_o.acc_sel = pcs_pkg::AccAdd;
        state_d       = pcs_pkg::StLast;
      end
      pcs_pkg::StLast: begin
        cmd_o.acc_sel = pcs_pkg::AccAddHi;
        state_d       = pcs_pkg::StFinish;
      end
      pcs_pkg::StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = pcs_pkg::StIdle;
        end
      end
      default: state_d = pcs_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/pcs_dp.sv =====
// Datapath of the PID step core: divider, shared multiplier, accumulator and state.
`timescale 1ns / 1ps
`default_nettype none
module pcs_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pcs_pkg::cfg_t                    cfg_i,
  input  wire pcs_pkg::cmd_t                    cmd_i,
  output pcs_pkg::sts_t                         sts_o,
  input  wire logic [1:0]                       req_type_i,
  input  wire logic signed [pcs_pkg::DataW-1:0] error_in_i,
  input  wire logic signed [pcs_pkg::DataW-1:0] rate_in_i,
  input  wire logic signed [pcs_pkg::DataW-1:0] sum_in_i,
  input  wire logic [pcs_pkg::DataW-1:0]        time_ms_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [pcs_pkg::DataW-1:0]      drive_o,
  output logic                                  limited_o
);

  localparam int DW = pcs_pkg::DataW;
  localparam int QW = pcs_pkg::QuoW;
  localparam int MW = pcs_pkg::MulW;
  localparam int PW = pcs_pkg::ProdW;
  localparam int IW = pcs_pkg::IntW;
  localparam int AW = pcs_pkg::AccW;
  localparam int SW = AW - pcs_pkg::FracW;

  pcs_pkg::req_type_e   type_q;
  logic signed [DW-1:0] e_q, rate_in_q, sum_in_q;
  logic [DW-1:0]        now_q, dt_q;
  logic [QW-1:0]        quo_q, rem_q;
  logic                 neg_q;
  logic [pcs_pkg::CntW-1:0] cnt_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic                 first_q;
  logic signed [IW-1:0] integ_q;
  logic signed [DW-1:0] last_err_q;
  logic [DW-1:0]        last_time_q;
  logic                 out_valid_q;
  logic signed [DW-1:0] drive_q;
  logic                 limited_q;

  logic [DW-1:0]        tdiff, dt_raw, dt_d;
  logic signed [QW-1:0] ediff;
  logic [QW-1:0]        emag, rem_sh;
  logic                 meas;
  logic signed [MW-1:0] rate_op, div_res, mul_a, mul_b;
  logic signed [IW-1:0] sum_op;
  logic signed [AW-1:0] prod_ext;
  logic signed [IW:0]   int_sum;
  logic signed [SW-1:0] shifted;
  logic signed [DW-1:0] res_sat, res_clamp;
  logic                 fits, lim_sat, lim_clamp;

  assign tdiff  = time_ms_i - last_time_q;
  assign dt_raw = cfg_i.fixed_interval ? {{(DW-pcs_pkg::PerW){1'b0}}, cfg_i.period} : tdiff;
  assign dt_d   = (dt_raw == '0) ? {{(DW-1){1'b0}}, 1'b1} : dt_raw;
  assign ediff  = QW'(error_in_i) - QW'(last_err_q);
  assign emag   = ediff[QW-1] ? QW'(-ediff) : ediff;
  assign rem_sh = {rem_q[QW-2:0], quo_q[QW-1]};

  assign meas    = (type_q == pcs_pkg::ReqAll);
  assign div_res = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_comb begin
    if (meas || (!first_q && type_q == pcs_pkg::ReqRate)) begin
      rate_op = MW'(rate_in_q);
    end else if (first_q) begin
      rate_op = '0;
    end else begin
      rate_op = div_res;
    end
    if (meas || (!first_q && type_q == pcs_pkg::ReqSum)) begin
      sum_op = IW'(sum_in_q);
    end else if (first_q) begin
      sum_op = '0;
    end else begin
      sum_op = integ_q;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      pcs_pkg::MulEdt: begin
        mul_a = MW'(e_q);
        mul_b = $signed({2'b00, dt_q});
      end
      pcs_pkg::MulKp: begin
        mul_a = MW'(cfg_i.kp);
        mul_b = MW'(e_q);
      end
      pcs_pkg::MulKd: begin
        mul_a = MW'(cfg_i.kd);
        mul_b = rate_op;
      end
      pcs_pkg::MulKiLo: begin
        mul_a = MW'(cfg_i.ki);
        mul_b = $signed({2'b00, sum_op[DW-1:0]});
      end
      pcs_pkg::MulKiHi: begin
        mul_a = MW'(cfg_i.ki);
        mul_b = MW'($signed(sum_op[IW-1:DW]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = AW'(prod_q);
  assign int_sum  = (IW+1)'(integ_q) + (IW+1)'($signed(prod_q[IW-1:0]));

  assign shifted = acc_q[AW-1:pcs_pkg::FracW];
  assign fits    = (shifted[SW-1:DW-1] == '0) || (shifted[SW-1:DW-1] == '1);
  assign res_sat = fits ? shifted[DW-1:0] :
                   (shifted[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
  assign lim_sat = !fits;

  always_comb begin
    res_clamp = res_sat;
    lim_clamp = lim_sat;
    if (cfg_i.limit_enable && !meas) begin
      if (res_clamp > cfg_i.out_high) begin
        res_clamp = cfg_i.out_high;
        lim_clamp = 1'b1;
      end
      if (res_clamp < cfg_i.out_low) begin
        res_clamp = cfg_i.out_low;
        lim_clamp = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q    <= pcs_pkg::req_type_e'(req_type_i);
      e_q       <= error_in_i;
      rate_in_q <= rate_in_i;
      sum_in_q  <= sum_in_i;
      now_q     <= time_ms_i;
      dt_q      <= dt_d;
      quo_q     <= emag;
      neg_q     <= ediff[QW-1];
      rem_q     <= '0;
      cnt_q     <= '0;
      acc_q     <= '0;
    end else begin
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (rem_sh >= {1'b0, dt_q}) begin
          rem_q <= rem_sh - {1'b0, dt_q};
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      case (cmd_i.acc_sel)
        pcs_pkg::AccAdd:   acc_q <= acc_q + prod_ext;
        pcs_pkg::AccSub:   acc_q <= acc_q - prod_ext;
        pcs_pkg::AccAddHi: acc_q <= acc_q + (prod_ext <<< DW);
        default: ;
      endcase
    end
    prod_q <= mul_a * mul_b;
    if (cmd_i.finish) begin
      drive_q   <= res_clamp;
      limited_q <= lim_clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      integ_q     <= '0;
      last_err_q  <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_sel == pcs_pkg::AccInteg) begin
        if (int_sum[IW] != int_sum[IW-1]) begin
          integ_q <= int_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
          integ_q <= int_sum[IW-1:0];
        end
      end
      if (cmd_i.finish && !meas) begin
        if (first_q) begin
          integ_q <= IW'(e_q);
          first_q <= 1'b0;
        end
        last_err_q <= e_q;
        if (!cfg_i.fixed_interval) begin
          last_time_q <= now_q;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.first    = first_q;
  assign sts_o.req_type = type_q;
  assign sts_o.div_last = (cnt_q == pcs_pkg::CntW'(pcs_pkg::DivSteps - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign limited_o   = limited_q;

endmodule
`default_nettype wire
